/* rtl/core/ftlb_pkg.sv */
// Shared sizes, command and cell-action codes, and the scan token for the translation buffer.
// Depends on nothing; every other file refers to it by scoped names.
package ftlb_pkg;

    localparam int ENTRIES     = 16;
    localparam int OFFSET_BITS = 12;
    localparam int USE_BITS    = 16;

    localparam int ADDR_W  = 32;
    localparam int PAGE_W  = ADDR_W - OFFSET_BITS;
    localparam int IDX_W   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 4;
    localparam int PERM_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 32;

    localparam logic [USE_BITS-1:0] USE_MAX  = {USE_BITS{1'b1}};
    localparam logic [USE_BITS-1:0] USE_NEW  = USE_BITS'(1);
    localparam logic [CNT_W-1:0]    CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [PERM_W-1:0]   GMASK_RST = 8'd32;

    // command codes carried by the kind field
    localparam logic [KIND_W-1:0] K_LOOKUP     = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT     = 3'd1;
    localparam logic [KIND_W-1:0] K_INV_PAGE   = 3'd2;
    localparam logic [KIND_W-1:0] K_INV_ALL    = 3'd3;
    localparam logic [KIND_W-1:0] K_INV_GLOBAL = 3'd4;
    localparam logic [KIND_W-1:0] K_CLR_STATS  = 3'd5;

    // actions broadcast to the cells
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_BUMP        = 3'd1;
    localparam logic [2:0] ACT_UPDATE      = 3'd2;
    localparam logic [2:0] ACT_FILL        = 3'd3;
    localparam logic [2:0] ACT_DROP        = 3'd4;
    localparam logic [2:0] ACT_DROP_ALL    = 3'd5;
    localparam logic [2:0] ACT_DROP_GLOBAL = 3'd6;

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     match_idx;
        logic [ADDR_W-1:0]    frame;
        logic [PERM_W-1:0]    perm;
        logic                 has_free;
        logic [IDX_W-1:0]     free_idx;
        logic [USE_BITS-1:0]  min_uses;
        logic [IDX_W-1:0]     min_idx;
    } t_scan;

    typedef struct packed {
        logic [2:0]           op;
        logic [IDX_W-1:0]     idx;
        logic [PAGE_W-1:0]    page;
        logic [ADDR_W-1:0]    frame;
        logic [PERM_W-1:0]    perm;
        logic [PERM_W-1:0]    gmask;
    } t_act;

    localparam t_scan SCAN_INIT = '{
        found:     1'b0,
        match_idx: '0,
        frame:     '0,
        perm:      '0,
        has_free:  1'b0,
        free_idx:  '0,
        min_uses:  USE_MAX,
        min_idx:   '0
    };

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* rtl/core/ftlb_cell.sv */
// One translation entry: holds page, frame, flags and use count, folds itself into the
// passing scan token and applies the broadcast action. Depends on ftlb_pkg.
module ftlb_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ftlb_pkg::IDX_W-1:0]    i_cell_idx,
    input  logic [ftlb_pkg::PAGE_W-1:0]   i_page,
    input  ftlb_pkg::t_scan               i_scan,
    input  logic                          i_scan_vld,
    input  ftlb_pkg::t_act                i_act,
    output ftlb_pkg::t_scan               o_scan,
    output logic                          o_scan_vld
);

    logic                               r_valid;
    logic [ftlb_pkg::PAGE_W-1:0]        r_page;
    logic [ftlb_pkg::ADDR_W-1:0]        r_frame;
    logic [ftlb_pkg::PERM_W-1:0]        r_perm;
    logic [ftlb_pkg::USE_BITS-1:0]      r_uses;
    ftlb_pkg::t_scan                    r_scan;
    logic                               r_scan_vld;
    ftlb_pkg::t_scan                    n_scan;
    logic [ftlb_pkg::USE_BITS-1:0]      n_uses_inc;
    logic                               w_sel;

    // fold this entry into the token: first match, first free slot, smallest count
    always_comb begin
        n_scan = i_scan;
        if (r_valid && (r_page == i_page) && !i_scan.found) begin
            n_scan.found     = 1'b1;
            n_scan.match_idx = i_cell_idx;
            n_scan.frame     = r_frame;
            n_scan.perm      = r_perm;
        end
        if (!r_valid && !i_scan.has_free) begin
            n_scan.has_free = 1'b1;
            n_scan.free_idx = i_cell_idx;
        end
        if (r_uses < i_scan.min_uses) begin
            n_scan.min_uses = r_uses;
            n_scan.min_idx  = i_cell_idx;
        end
    end

    assign n_uses_inc = (r_uses == ftlb_pkg::USE_MAX) ? r_uses : r_uses + 1'b1;
    assign w_sel      = (i_act.idx == i_cell_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= i_scan_vld;
        end
        if (i_scan_vld) begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_uses  <= '0;
        end else begin
            unique case (i_act.op)
                ftlb_pkg::ACT_BUMP: begin
                    if (w_sel) begin
                        r_uses <= n_uses_inc;
                    end
                end
                ftlb_pkg::ACT_UPDATE: begin
                    if (w_sel) begin
                        r_uses  <= n_uses_inc;
                        r_frame <= i_act.frame;
                        r_perm  <= i_act.perm;
                    end
                end
                ftlb_pkg::ACT_FILL: begin
                    if (w_sel) begin
                        r_valid <= 1'b1;
                        r_uses  <= ftlb_pkg::USE_NEW;
                        r_page  <= i_act.page;
                        r_frame <= i_act.frame;
                        r_perm  <= i_act.perm;
                    end
                end
                ftlb_pkg::ACT_DROP: begin
                    if (w_sel) begin
                        r_valid <= 1'b0;
                        r_uses  <= '0;
                    end
                end
                ftlb_pkg::ACT_DROP_ALL: begin
                    r_valid <= 1'b0;
                    r_uses  <= '0;
                end
                ftlb_pkg::ACT_DROP_GLOBAL: begin
                    if (r_valid && ((r_perm & i_act.gmask) != '0)) begin
                        r_valid <= 1'b0;
                        r_uses  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_scan     = r_scan;
    assign o_scan_vld = r_scan_vld;

endmodule

/* rtl/core/fully_assoc_tlb_lfu.sv */
// Top level of the fully associative translation buffer with least-frequently-used
// replacement. Depends on ftlb_pkg and ftlb_cell.
//
// Each transaction on the input channel is one command (lookup, insert, invalidate page,
// invalidate all, invalidate global, clear statistics) and yields exactly one result
// transaction. The entries sit in a row of ENTRIES cells. After a command is taken, a scan
// token walks down the row one cell per clock, picking up the first matching entry, the
// lowest free slot and the lowest-index entry with the smallest use count. When the token
// leaves the last cell it is captured, and the command is resolved as soon as the result
// register is empty or not stalled: one action is broadcast to all cells, a lookup moves
// the hit or miss counter, and the result register loads. The token passes the start
// register, every cell of the row and the capture register before the result loads, and
// the next command can be taken once it has loaded; the length of the cell row sets both.
// One command is in flight at a time and o_stall stays high meanwhile. The next command is
// taken while a finished result still waits in the output register; resolution of that
// next command holds only if the previous result is still stalled. global_mask (reset 32)
// selects the flag bits that mark an entry global; write it only while idle.
module fully_assoc_tlb_lfu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ftlb_pkg::KIND_W-1:0]   i_kind,
    input  logic [ftlb_pkg::ADDR_W-1:0]   i_vaddr_in,
    input  logic [ftlb_pkg::ADDR_W-1:0]   i_paddr_in,
    input  logic [ftlb_pkg::PERM_W-1:0]   i_perm_bits,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [ftlb_pkg::ADDR_W-1:0]   o_paddr_out,
    output logic [ftlb_pkg::PERM_W-1:0]   o_perm_out,
    output logic [ftlb_pkg::SLOT_W-1:0]   o_slot_used,
    output logic [ftlb_pkg::CNT_W-1:0]    o_hits_total,
    output logic [ftlb_pkg::CNT_W-1:0]    o_misses_total,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ftlb_pkg::PERM_W-1:0]   i_cfg_data
);

    // command latched at acceptance
    logic                               r_busy;
    logic                               r_start;
    logic [ftlb_pkg::KIND_W-1:0]        r_kind;
    logic [ftlb_pkg::PAGE_W-1:0]        r_page;
    logic [ftlb_pkg::ADDR_W-1:0]        r_frame;
    logic [ftlb_pkg::PERM_W-1:0]        r_perm;
    logic [ftlb_pkg::PERM_W-1:0]        r_gmask;

    // token captured at the end of the row
    ftlb_pkg::t_scan                    r_tok;
    logic                               r_tok_vld;

    // statistics and result register
    logic [ftlb_pkg::CNT_W-1:0]         r_hits;
    logic [ftlb_pkg::CNT_W-1:0]         r_misses;
    logic                               r_out_vld;
    logic                               r_found;
    logic [ftlb_pkg::ADDR_W-1:0]        r_paddr;
    logic [ftlb_pkg::PERM_W-1:0]        r_pout;
    logic [ftlb_pkg::SLOT_W-1:0]        r_slot;

    logic [ftlb_pkg::CNT_W-1:0]         n_hits;
    logic [ftlb_pkg::CNT_W-1:0]         n_misses;
    logic                               n_found;
    logic [ftlb_pkg::ADDR_W-1:0]        n_paddr;
    logic [ftlb_pkg::PERM_W-1:0]        n_pout;
    logic [ftlb_pkg::SLOT_W-1:0]        n_slot;
    ftlb_pkg::t_act                     w_act;

    ftlb_pkg::t_scan                    w_scan [ftlb_pkg::ENTRIES+1];
    logic [ftlb_pkg::ENTRIES:0]         w_scan_vld;

    logic                               w_accept;
    logic                               w_apply;
    logic [ftlb_pkg::IDX_W-1:0]         w_victim;

    assign w_accept    = i_valid && !r_busy;
    assign w_apply     = r_tok_vld && (!r_out_vld || !i_stall);
    assign o_stall     = r_busy;
    assign o_cfg_ready = 1'b1;

    // take a command, launch the token, hold until it is resolved
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_start   <= 1'b0;
            r_tok_vld <= 1'b0;
            r_gmask   <= ftlb_pkg::GMASK_RST;
        end else begin
            r_start <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_apply) begin
                r_busy <= 1'b0;
            end
            if (w_scan_vld[ftlb_pkg::ENTRIES]) begin
                r_tok_vld <= 1'b1;
            end else if (w_apply) begin
                r_tok_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_gmask <= i_cfg_data;
            end
        end
        if (w_accept) begin
            r_kind  <= i_kind;
            r_page  <= i_vaddr_in[ftlb_pkg::ADDR_W-1:ftlb_pkg::OFFSET_BITS];
            r_frame <= i_paddr_in;
            r_perm  <= i_perm_bits;
        end
        if (w_scan_vld[ftlb_pkg::ENTRIES]) begin
            r_tok <= w_scan[ftlb_pkg::ENTRIES];
        end
    end

    // the token enters the row fresh, in the cycle after acceptance
    assign w_scan[0]     = ftlb_pkg::SCAN_INIT;
    assign w_scan_vld[0] = r_start;

    for (genvar g = 0; g < ftlb_pkg::ENTRIES; g++) begin : g_cell
        ftlb_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (ftlb_pkg::IDX_W'(g)),
            .i_page     (r_page),
            .i_scan     (w_scan[g]),
            .i_scan_vld (w_scan_vld[g]),
            .i_act      (w_act),
            .o_scan     (w_scan[g+1]),
            .o_scan_vld (w_scan_vld[g+1])
        );
    end

    // an insert that misses takes the lowest free slot, else the least used one
    assign w_victim = r_tok.has_free ? r_tok.free_idx : r_tok.min_idx;

    // resolve the command from the finished token
    always_comb begin
        w_act       = '0;
        w_act.op    = ftlb_pkg::ACT_NONE;
        w_act.page  = r_page;
        w_act.frame = r_frame;
        w_act.perm  = r_perm;
        w_act.gmask = r_gmask;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_found     = 1'b0;
        n_paddr     = '0;
        n_pout      = '0;
        n_slot      = '0;
        unique case (r_kind)
            ftlb_pkg::K_LOOKUP: begin
                if (r_tok.found) begin
                    w_act.op  = ftlb_pkg::ACT_BUMP;
                    w_act.idx = r_tok.match_idx;
                    n_found   = 1'b1;
                    n_paddr   = r_tok.frame;
                    n_pout    = r_tok.perm;
                    n_slot    = ftlb_pkg::slot_of(r_tok.match_idx);
                    if (r_hits != ftlb_pkg::CNT_MAX) begin
                        n_hits = r_hits + 1'b1;
                    end
                end else if (r_misses != ftlb_pkg::CNT_MAX) begin
                    n_misses = r_misses + 1'b1;
                end
            end
            ftlb_pkg::K_INSERT: begin
                if (r_tok.found) begin
                    w_act.op  = ftlb_pkg::ACT_UPDATE;
                    w_act.idx = r_tok.match_idx;
                    n_found   = 1'b1;
                    n_paddr   = r_frame;
                    n_pout    = r_perm;
                    n_slot    = ftlb_pkg::slot_of(r_tok.match_idx);
                end else begin
                    w_act.op  = ftlb_pkg::ACT_FILL;
                    w_act.idx = w_victim;
                    n_slot    = ftlb_pkg::slot_of(w_victim);
                end
            end
            ftlb_pkg::K_INV_PAGE: begin
                if (r_tok.found) begin
                    w_act.op  = ftlb_pkg::ACT_DROP;
                    w_act.idx = r_tok.match_idx;
                end
            end
            ftlb_pkg::K_INV_ALL: begin
                w_act.op = ftlb_pkg::ACT_DROP_ALL;
            end
            ftlb_pkg::K_INV_GLOBAL: begin
                w_act.op = ftlb_pkg::ACT_DROP_GLOBAL;
            end
            ftlb_pkg::K_CLR_STATS: begin
                n_hits   = '0;
                n_misses = '0;
            end
            default: begin
            end
        endcase
        // drop everything unless the result can be loaded this cycle
        if (!w_apply) begin
            w_act.op = ftlb_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits    <= '0;
            r_misses  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_apply) begin
                r_hits    <= n_hits;
                r_misses  <= n_misses;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (w_apply) begin
            r_found <= n_found;
            r_paddr <= n_paddr;
            r_pout  <= n_pout;
            r_slot  <= n_slot;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_found        = r_found;
    assign o_paddr_out    = r_paddr;
    assign o_perm_out     = r_pout;
    assign o_slot_used    = r_slot;
    assign o_hits_total   = r_hits;
    assign o_misses_total = r_misses;

    // only one token may travel the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_scan_vld, r_tok_vld}))
        else $error("more than one scan token in flight");

    // a captured token always belongs to an open command
    a_tok_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_vld |-> r_busy)
        else $error("scan token without an open command");

    // acceptance launches the token on the next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_scan_vld[0])
        else $error("token not launched after acceptance");

    // resolution closes the command and loads a result
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |=> (!r_busy || $past(w_accept)) && r_out_vld)
        else $error("command not closed after resolution");

endmodule
